// ===== src/brlh_pkg.sv =====
// Shared types and codes for the bit run-length histogram unit.
// No dependencies; used by the interfaces, the histogram RAM and the top level.
package brlh_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // fixed field widths of the channels
  localparam int unsigned OpW    = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 7;
  localparam int unsigned CountW = 16;

  // histogram RAM control from the sequencer
  typedef struct packed {
    logic rd;   // read entry at addr
    logic inc;  // write back read value plus one, saturating
    logic clr;  // write zero at addr
  } ram_ctrl_t;

endpackage

// ===== src/brlh_in_if.sv =====
// Request channel of the bit run-length histogram unit.
// Depends on brlh_pkg for field widths.
interface brlh_in_if;
  logic                           valid;
  logic                           ready;
  logic [brlh_pkg::OpW-1:0]       op;
  logic [brlh_pkg::ByteW-1:0]     data_byte;
  logic                           last_byte;
  logic                           read_bit;
  logic [brlh_pkg::LenW-1:0]      read_length;

  modport source (output valid, op, data_byte, last_byte, read_bit, read_length,
                  input ready);
  modport sink (input valid, op, data_byte, last_byte, read_bit, read_length,
                output ready);
endinterface

// ===== src/brlh_out_if.sv =====
// Result channel of the bit run-length histogram unit.
// Depends on brlh_pkg for field widths.
interface brlh_out_if;
  logic                           valid;
  logic                           ready;
  logic [brlh_pkg::CountW-1:0]    bin_count;
  logic [brlh_pkg::LenW-1:0]      bin_length;

  modport source (output valid, bin_count, bin_length, input ready);
  modport sink (input valid, bin_count, bin_length, output ready);
endinterface

// ===== src/brlh_hist_ram.sv =====
// Histogram counter RAM: one port for read or clear, registered read data,
// and a read-modify-write stage that stores the saturated increment. Uses brlh_pkg.
module brlh_hist_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned CW    = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  brlh_pkg::ram_ctrl_t         ctrl,
  input  logic [$clog2(DEPTH)-1:0]    addr,
  output logic [CW-1:0]               q
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [CW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_addr;
  logic          wr_pend;
  logic [CW-1:0] q_inc;

  assign q_inc = (q == {CW{1'b1}}) ? q : q + CW'(1);

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      q <= mem[addr];
    end
    if (ctrl.clr) begin
      mem[addr] <= '0;
    end else if (wr_pend) begin
      mem[wr_addr] <= q_inc;
    end
    wr_addr <= addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= ctrl.rd && ctrl.inc;
    end
  end

  // sweep writes and increment writes share the port and must never meet
  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.clr && wr_pend))
    else $error("clear write collides with pending increment");

  // back-to-back increments alternate bit value, so never the same entry
  a_no_rmw_hazard: assert property (@(posedge clk) disable iff (rst)
    (ctrl.rd && wr_pend) |-> (addr != wr_addr))
    else $error("read of an entry whose increment is still pending");

endmodule

// ===== src/bit_run_length_histogram_unit.sv =====
// Bit run-length histogram unit: top level with the bit-serial run tracker,
// the item sequencer and the result register. Uses brlh_pkg, brlh_in_if,
// brlh_out_if and brlh_hist_ram.
//
// Requests arrive on req (valid/ready), one item per handshake. A push item
// loads its byte into a shift register that feeds one bit per cycle, least
// significant first, into the run tracker; each finished run increments one
// counter in the histogram RAM. req.ready is high only while the sequencer
// is idle: a push holds it low through its shift phase, and through the
// close step too when the last flag closes the open run, so a new byte is
// taken only once the previous one is fully shifted in and closed.
// A read item reads its counter in S_READ and puts the result into the output
// register from S_RESP, at the same edge that frees req. The output register
// parts the two channels: pushes and clears go on while a result waits
// on rsp; a second read waits in its response step until rsp takes the
// first one. A clear item, and reset, sweep zeros through all 2*BINS
// counters one per cycle, keeping req.ready low, and drop the open run.
module bit_run_length_histogram_unit #(
  parameter int unsigned BINS        = 64,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  brlh_in_if.sink       req,
  brlh_out_if.source    rsp
);

  localparam int unsigned DEPTH = 2 * BINS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LW    = $clog2(BINS + 1);
  localparam int unsigned QW    = (COUNT_WIDTH > brlh_pkg::CountW) ?
                                  COUNT_WIDTH : brlh_pkg::CountW;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_CLOSE = 6'b001000,
    S_READ  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t                          state, state_next;
  logic [AW-1:0]                   clr_idx;
  logic [brlh_pkg::ByteW-1:0]      shreg;
  logic [2:0]                      bit_cnt;
  logic                            last;
  logic                            cur_bit;
  logic [LW-1:0]                   run_len;
  logic                            run_open;
  logic                            rd_bit;
  logic [brlh_pkg::LenW-1:0]       rd_len;
  logic                            out_valid;
  logic [brlh_pkg::CountW-1:0]     out_count;
  logic [brlh_pkg::LenW-1:0]       out_len;

  logic                            acc;
  logic                            new_bit;
  logic                            run_end;
  logic                            sel_bit;
  logic [LW-1:0]                   sel_len;
  logic [LW-1:0]                   rd_len_c;
  logic [AW-1:0]                   calc_addr;
  brlh_pkg::ram_ctrl_t             ctrl;
  logic [AW-1:0]                   ram_addr;
  logic [COUNT_WIDTH-1:0]          ram_q;
  logic [QW-1:0]                   q_ext;
  logic                            resp_load;

  assign req.ready     = (state == S_IDLE);
  assign acc           = req.valid && req.ready;
  assign rsp.valid     = out_valid;
  assign rsp.bin_count = out_count;
  assign rsp.bin_length = out_len;

  assign new_bit = shreg[0];
  assign run_end = run_open && (new_bit != cur_bit);

  // read length clamped into the top bin
  assign rd_len_c = (int'(rd_len) > BINS) ? LW'(BINS) : LW'(rd_len);

  always_comb begin
    if (state == S_READ) begin
      sel_bit = rd_bit;
      sel_len = rd_len_c;
    end else begin
      sel_bit = cur_bit;
      sel_len = run_len;
    end
    calc_addr = AW'(sel_len) - AW'(1);
    if (sel_bit) begin
      calc_addr = calc_addr + AW'(BINS);
    end
  end

  always_comb begin
    ctrl     = '0;
    ram_addr = calc_addr;
    case (state)
      S_CLEAR: begin
        ctrl.clr = 1'b1;
        ram_addr = clr_idx;
      end
      S_SHIFT: begin
        ctrl.rd  = run_end;
        ctrl.inc = run_end;
      end
      S_CLOSE: begin
        ctrl.rd  = run_open;
        ctrl.inc = run_open;
      end
      S_READ: begin
        ctrl.rd = (rd_len != '0);
      end
      default: begin
      end
    endcase
  end

  brlh_hist_ram #(
    .DEPTH (DEPTH),
    .CW    (COUNT_WIDTH)
  ) u_ram (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .addr (ram_addr),
    .q    (ram_q)
  );

  assign q_ext     = QW'(ram_q);
  assign resp_load = (state == S_RESP) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == AW'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          case (req.op)
            brlh_pkg::OP_PUSH:  state_next = S_SHIFT;
            brlh_pkg::OP_READ:  state_next = S_READ;
            brlh_pkg::OP_CLEAR: state_next = S_CLEAR;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_SHIFT: begin
        if (bit_cnt == 3'd7) state_next = last ? S_CLOSE : S_IDLE;
      end
      S_CLOSE: state_next = S_IDLE;
      S_READ:  state_next = S_RESP;
      S_RESP: begin
        if (resp_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      bit_cnt   <= '0;
      cur_bit   <= 1'b0;
      run_len   <= '0;
      run_open  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end

      if (acc && req.op == brlh_pkg::OP_PUSH) begin
        bit_cnt <= '0;
      end else if (state == S_SHIFT) begin
        bit_cnt <= bit_cnt + 3'd1;
      end

      if (acc && req.op == brlh_pkg::OP_CLEAR) begin
        clr_idx  <= '0;
        cur_bit  <= 1'b0;
        run_len  <= '0;
        run_open <= 1'b0;
      end else if (state == S_SHIFT) begin
        if (!run_open || run_end) begin
          cur_bit  <= new_bit;
          run_len  <= LW'(1);
          run_open <= 1'b1;
        end else if (run_len != LW'(BINS)) begin
          run_len <= run_len + LW'(1);
        end
      end else if (state == S_CLOSE) begin
        cur_bit  <= 1'b0;
        run_len  <= '0;
        run_open <= 1'b0;
      end

      if (resp_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      shreg  <= req.data_byte;
      last   <= req.last_byte;
      rd_bit <= req.read_bit;
      rd_len <= req.read_length;
    end else if (state == S_SHIFT) begin
      shreg <= {1'b0, shreg[brlh_pkg::ByteW-1:1]};
    end
    if (resp_load) begin
      out_len <= rd_len;
      if (rd_len == '0) begin
        out_count <= '0;
      end else if (q_ext > QW'({brlh_pkg::CountW{1'b1}})) begin
        out_count <= {brlh_pkg::CountW{1'b1}};
      end else begin
        out_count <= q_ext[brlh_pkg::CountW-1:0];
      end
    end
  end

  // a byte is always exactly eight shift steps
  a_eight_bits: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && bit_cnt == 3'd7) |=> (state != S_SHIFT))
    else $error("shift phase ran past eight bits");

  // closing the stream leaves no run open
  a_close_drops_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLOSE) |=> (!run_open && run_len == '0))
    else $error("open run survived the last-byte close");

  // an open run is never longer than the top bin
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    run_open |-> (run_len != '0 && int'(run_len) <= BINS))
    else $error("run length out of range");

endmodule

// ===== sim/tb_bit_run_length_histogram_unit.sv =====
// Testbench for bit_run_length_histogram_unit: drives push/read/clear items
// and checks every bin read against a run-length histogram predictor.
// Depends on brlh_pkg, brlh_in_if, brlh_out_if and the unit's RTL.
module tb_bit_run_length_histogram_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BINS        = 64;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned OP_W        = brlh_pkg::OpW;
  localparam int unsigned BYTE_W      = brlh_pkg::ByteW;
  localparam int unsigned LEN_W       = brlh_pkg::LenW;
  localparam int unsigned CNT_W       = brlh_pkg::CountW;
  localparam int unsigned COUNT_TOP   = (1 << COUNT_WIDTH) - 1;
  localparam int unsigned READ_TOP    = 16'hFFFF;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // not decoded, must be ignored
  localparam int unsigned ITEM_GOAL   = 1450;
  localparam int unsigned CALM_ITEMS  = 200;   // no idling over the last items
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              rbit;
    logic [LEN_W-1:0]  rlen;
  } req_item_t;

  typedef struct {
    logic [CNT_W-1:0] count;
    logic [LEN_W-1:0] length;
  } bin_result_t;

  logic clk;
  logic rst;

  brlh_in_if  req_if ();
  brlh_out_if rsp_if ();

  bit_run_length_histogram_unit #(
    .BINS        (BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // predictor state
  int unsigned run_hist [2*BINS];
  logic        run_bit;
  int unsigned run_len;
  logic        run_live;

  req_item_t   requests_to_send [$];
  bin_result_t expected_bins [$];

  int unsigned total_items;
  int unsigned accepted_items;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned stall_cycles;
  logic        calm;
  logic        req_hs;
  logic        rsp_hs;
  int unsigned src_gap;
  int unsigned sink_gap;
  int unsigned hold_left;
  int unsigned holds_done;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void enqueue(int unsigned op, int unsigned data, int unsigned last,
                                   int unsigned rbit, int unsigned rlen);
    req_item_t it;
    it.op   = OP_W'(op);
    it.data = BYTE_W'(data);
    it.last = last[0];
    it.rbit = rbit[0];
    it.rlen = LEN_W'(rlen);
    requests_to_send = {requests_to_send, it};
    total_items++;
  endfunction

  // byte patterns that give short runs, long runs and single edges
  function automatic logic [BYTE_W-1:0] pick_byte();
    logic [BYTE_W-1:0] b;
    case ($urandom_range(0, 5))
      0, 1: b = BYTE_W'($urandom_range(0, 255));
      2: b = 8'h00;
      3: b = 8'hFF;
      4: begin
        b = 8'hFF << $urandom_range(0, 7);
        if ($urandom_range(0, 1)) b = ~b;
      end
      default: b = $urandom_range(0, 1) ? 8'h55 : 8'hAA;
    endcase
    return b;
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return LEN_W'($urandom_range(1, 10));
    if (r == 7) return LEN_W'($urandom_range(BINS - 4, BINS));
    return LEN_W'($urandom_range(0, 127));
  endfunction

  function automatic void enqueue_read();
    enqueue(brlh_pkg::OP_READ, $urandom_range(0, 255), $urandom_range(0, 1),
            $urandom_range(0, 1), pick_length());
  endfunction

  function void tally_run(logic b, int unsigned n);
    int unsigned idx;
    if (n == 0) return;
    if (n > BINS) n = BINS;
    idx = (b ? BINS : 0) + n - 1;
    if (run_hist[idx] < COUNT_TOP) run_hist[idx]++;
  endfunction

  function void drop_run();
    run_bit  = 1'b0;
    run_len  = 0;
    run_live = 1'b0;
  endfunction

  function void feed_bit(logic b);
    if (!run_live) begin
      run_bit  = b;
      run_len  = 1;
      run_live = 1'b1;
    end else if (b == run_bit) begin
      if (run_len < BINS) run_len++;
    end else begin
      tally_run(run_bit, run_len);
      run_bit = b;
      run_len = 1;
    end
  endfunction

  function void histogram_apply(req_item_t it);
    bin_result_t res;
    int unsigned n;
    int unsigned idx;
    int unsigned cnt;
    case (it.op)
      brlh_pkg::OP_PUSH: begin
        for (int i = 0; i < BYTE_W; i++) feed_bit(it.data[i]);
        if (it.last) begin
          if (run_live) tally_run(run_bit, run_len);
          drop_run();
        end
      end
      brlh_pkg::OP_READ: begin
        res.count  = '0;
        res.length = it.rlen;
        if (it.rlen != 0) begin
          n   = (it.rlen > BINS) ? BINS : it.rlen;
          idx = (it.rbit ? BINS : 0) + n - 1;
          cnt = (run_hist[idx] > READ_TOP) ? READ_TOP : run_hist[idx];
          res.count = CNT_W'(cnt);
        end
        expected_bins = {expected_bins, res};
      end
      brlh_pkg::OP_CLEAR: begin
        foreach (run_hist[i]) run_hist[i] = 0;
        drop_run();
      end
      default: ;
    endcase
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    req_item_t   it;
    bin_result_t want;
    if (rst) begin
      req_hs       = 1'b0;
      rsp_hs       = 1'b0;
      stall_cycles = 0;
    end else begin
      req_hs = req_if.valid && req_if.ready;
      rsp_hs = rsp_if.valid && rsp_if.ready;
      if (req_hs) begin
        it.op   = req_if.op;
        it.data = req_if.data_byte;
        it.last = req_if.last_byte;
        it.rbit = req_if.read_bit;
        it.rlen = req_if.read_length;
        histogram_apply(it);
        accepted_items++;
      end
      if (rsp_hs) begin
        results_seen++;
        if (expected_bins.size() == 0) begin
          $display("%0t: unexpected result, count %0d length %0d", $realtime,
                   rsp_if.bin_count, rsp_if.bin_length);
          error_count++;
        end else begin
          want = expected_bins.pop_front();
          if (rsp_if.bin_count !== want.count || rsp_if.bin_length !== want.length) begin
            $display("%0t: bin mismatch, expected count %0d length %0d, got count %0d length %0d",
                     $realtime, want.count, want.length, rsp_if.bin_count, rsp_if.bin_length);
            error_count++;
          end
        end
      end
      stall_cycles = (req_hs || rsp_hs) ? 0 : stall_cycles + 1;
      calm = (accepted_items + CALM_ITEMS >= total_items);
    end
  end

  // request driver, fed from the item queue
  always @(negedge clk) begin
    req_item_t it;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_hs) begin
      if (src_gap > 0) begin
        src_gap--;
        req_if.valid <= 1'b0;
      end else if (requests_to_send.size() == 0) begin
        req_if.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(1, 19) - 1;
        req_if.valid <= 1'b0;
      end else begin
        it = requests_to_send.pop_front();
        req_if.valid       <= 1'b1;
        req_if.op          <= it.op;
        req_if.data_byte   <= it.data;
        req_if.last_byte   <= it.last;
        req_if.read_bit    <= it.rbit;
        req_if.read_length <= it.rlen;
      end
    end
  end

  // result sink with random stalls and two long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (holds_done < 2 && results_seen >= 25 + 125 * holds_done) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      rsp_if.ready <= 1'b0;
    end else if (calm) begin
      rsp_if.ready <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap--;
      rsp_if.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(1, 19) - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(negedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned nbytes;
    logic [BYTE_W-1:0] fill;
    rst                = 1'b1;
    req_if.valid       = 1'b0;
    req_if.op          = brlh_pkg::OP_PUSH;
    req_if.data_byte   = '0;
    req_if.last_byte   = 1'b0;
    req_if.read_bit    = 1'b0;
    req_if.read_length = '0;
    rsp_if.ready       = 1'b0;
    total_items    = 0;
    accepted_items = 0;
    results_seen   = 0;
    error_count    = 0;
    calm           = 1'b0;
    src_gap        = 0;
    sink_gap       = 0;
    hold_left      = 0;
    holds_done     = 0;
    foreach (run_hist[i]) run_hist[i] = 0;
    drop_run();

    // directed: empty histogram, a 72-bit zero run into the top bin,
    // zero and over-range lengths, reads with a run open, unused op, clear
    enqueue(brlh_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 7'd1);
    repeat (9) enqueue(brlh_pkg::OP_PUSH, 8'h00, 1'b0, 1'b0, 7'd0);
    enqueue(brlh_pkg::OP_PUSH, 8'hFF, 1'b1, 1'b0, 7'd0);
    enqueue(brlh_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 7'd64);
    enqueue(brlh_pkg::OP_READ, 8'hFF, 1'b1, 1'b0, 7'd127);
    enqueue(brlh_pkg::OP_READ, 8'h00, 1'b0, 1'b1, 7'd8);
    enqueue(brlh_pkg::OP_READ, 8'h00, 1'b0, 1'b1, 7'd0);
    enqueue(brlh_pkg::OP_PUSH, 8'hAA, 1'b0, 1'b1, 7'd127);
    enqueue(brlh_pkg::OP_READ, 8'h00, 1'b0, 1'b1, 7'd1);
    enqueue(OP_SPARE, 8'hFF, 1'b1, 1'b1, 7'd127);
    enqueue(brlh_pkg::OP_PUSH, 8'h55, 1'b1, 1'b0, 7'd0);
    enqueue(brlh_pkg::OP_READ, 8'h00, 1'b0, 1'b1, 7'd2);
    enqueue(brlh_pkg::OP_CLEAR, 8'hFF, 1'b1, 1'b1, 7'd127);
    enqueue(brlh_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 7'd64);
    enqueue(brlh_pkg::OP_PUSH, 8'h0F, 1'b1, 1'b0, 7'd0);
    enqueue(brlh_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 7'd4);
    enqueue(brlh_pkg::OP_READ, 8'h00, 1'b0, 1'b1, 7'd4);

    // random: mostly streams closed by the last flag, reads in between
    while (total_items < ITEM_GOAL) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        enqueue(brlh_pkg::OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 1),
                $urandom_range(0, 1), $urandom_range(0, 127));
      end else if (r < 6) begin
        enqueue(OP_SPARE, $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 127));
      end else if (r < 80) begin
        // long-run streams can reach past the top bin
        nbytes = (r < 14) ? $urandom_range(7, 11) : $urandom_range(1, 10);
        fill   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        for (int k = 0; k < nbytes; k++) begin
          enqueue(brlh_pkg::OP_PUSH, (r < 14) ? fill : pick_byte(),
                  (k == nbytes - 1) && ($urandom_range(0, 9) != 0),
                  $urandom_range(0, 1), $urandom_range(0, 127));
          if ($urandom_range(0, 5) == 0) enqueue_read();
        end
      end else begin
        repeat ($urandom_range(1, 4)) enqueue_read();
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_items < total_items || expected_bins.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
